// ===== rtl/kpvf_pkg.sv =====
// Shared types, constants and the micro-op program of the Kalman position/velocity filter.
// No dependencies; used by the interfaces' users, the controller, the datapath and the top.
package kpvf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COV_WIDTH_DEF = 48;

  typedef enum logic [3:0] {
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB,
    OP_SHR1,
    OP_SHR2,
    OP_C32,
    OP_CCOV,
    OP_CVAR,
    OP_OUTA,
    OP_OUTB
  } op_e;

  // operand / destination addresses: 0..15 register file, 16 and up are fixed sources
  localparam logic [4:0] A_P      = 5'd0;
  localparam logic [4:0] A_V      = 5'd1;
  localparam logic [4:0] A_CPP    = 5'd2;
  localparam logic [4:0] A_CPV    = 5'd3;
  localparam logic [4:0] A_CVV    = 5'd4;
  localparam logic [4:0] A_T0     = 5'd5;
  localparam logic [4:0] A_T1     = 5'd6;
  localparam logic [4:0] A_T2     = 5'd7;
  localparam logic [4:0] A_T3     = 5'd8;
  localparam logic [4:0] A_T4     = 5'd9;
  localparam logic [4:0] A_T5     = 5'd10;
  localparam logic [4:0] A_T6     = 5'd11;
  localparam logic [4:0] A_T7     = 5'd12;
  localparam logic [4:0] A_T8     = 5'd13;
  localparam logic [4:0] A_T9     = 5'd14;
  localparam logic [4:0] A_MEAS   = 5'd16;
  localparam logic [4:0] A_VARZ   = 5'd17;
  localparam logic [4:0] A_DT     = 5'd18;
  localparam logic [4:0] A_ACC    = 5'd19;
  localparam logic [4:0] A_SVEL   = 5'd20;
  localparam logic [4:0] A_ZERO   = 5'd21;
  localparam logic [4:0] A_INITPP = 5'd22;

  localparam logic [5:0] PC_UPD = 6'd0;
  localparam logic [5:0] PC_RST = 6'd45;
  localparam logic [5:0] PC_REJ = 6'd50;

  localparam logic [7:0] MUL_LAST = 8'd6;
  localparam logic [7:0] DIV_LAST = 8'd129;

  typedef struct packed {
    op_e        op;
    logic [4:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
    logic       is_last;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic exec;
    logic rej;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic dt_zero;
  } dp_stat_t;

  function automatic uop_t mk(op_e op, logic [4:0] d, logic [4:0] a, logic [4:0] b,
                              logic is_last);
    uop_t u;
    u.op      = op;
    u.dst     = d;
    u.src_a   = a;
    u.src_b   = b;
    u.is_last = is_last;
    return u;
  endfunction

  // update program at PC_UPD, reset-item program at PC_RST, output tail at PC_REJ
  function automatic uop_t uop_rom(logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MUL,  A_T0,   A_DT,     A_DT,   1'b0); // dt^2
      6'd1:  u = mk(OP_MUL,  A_T1,   A_DT,     A_T0,   1'b0); // dt^3
      6'd2:  u = mk(OP_MUL,  A_T2,   A_T0,     A_T0,   1'b0); // dt^4
      6'd3:  u = mk(OP_MUL,  A_T3,   A_V,      A_DT,   1'b0);
      6'd4:  u = mk(OP_ADD,  A_T3,   A_P,      A_T3,   1'b0);
      6'd5:  u = mk(OP_C32,  A_P,    A_T3,     A_ZERO, 1'b0);
      6'd6:  u = mk(OP_MUL,  A_T3,   A_CPV,    A_DT,   1'b0);
      6'd7:  u = mk(OP_ADD,  A_T3,   A_T3,     A_T3,   1'b0);
      6'd8:  u = mk(OP_ADD,  A_T3,   A_CPP,    A_T3,   1'b0);
      6'd9:  u = mk(OP_MUL,  A_T4,   A_T0,     A_CVV,  1'b0);
      6'd10: u = mk(OP_ADD,  A_T3,   A_T3,     A_T4,   1'b0);
      6'd11: u = mk(OP_MUL,  A_T4,   A_ACC,    A_T2,   1'b0);
      6'd12: u = mk(OP_SHR2, A_T4,   A_T4,     A_ZERO, 1'b0);
      6'd13: u = mk(OP_ADD,  A_T3,   A_T3,     A_T4,   1'b0);
      6'd14: u = mk(OP_MUL,  A_T4,   A_DT,     A_CVV,  1'b0);
      6'd15: u = mk(OP_ADD,  A_T4,   A_CPV,    A_T4,   1'b0);
      6'd16: u = mk(OP_MUL,  A_T5,   A_ACC,    A_T1,   1'b0);
      6'd17: u = mk(OP_SHR1, A_T5,   A_T5,     A_ZERO, 1'b0);
      6'd18: u = mk(OP_ADD,  A_T4,   A_T4,     A_T5,   1'b0);
      6'd19: u = mk(OP_MUL,  A_T5,   A_ACC,    A_T0,   1'b0);
      6'd20: u = mk(OP_ADD,  A_T5,   A_CVV,    A_T5,   1'b0);
      6'd21: u = mk(OP_CVAR, A_T3,   A_T3,     A_ZERO, 1'b0); // predicted pp
      6'd22: u = mk(OP_CCOV, A_T4,   A_T4,     A_ZERO, 1'b0); // predicted pv
      6'd23: u = mk(OP_CVAR, A_T5,   A_T5,     A_ZERO, 1'b0); // predicted vv
      6'd24: u = mk(OP_SUB,  A_T6,   A_MEAS,   A_P,    1'b0); // innovation
      6'd25: u = mk(OP_ADD,  A_T7,   A_T3,     A_VARZ, 1'b0); // innovation variance
      6'd26: u = mk(OP_DIV,  A_T8,   A_T3,     A_T7,   1'b0); // position gain
      6'd27: u = mk(OP_DIV,  A_T9,   A_T4,     A_T7,   1'b0); // velocity gain
      6'd28: u = mk(OP_MUL,  A_T0,   A_T8,     A_T6,   1'b0);
      6'd29: u = mk(OP_ADD,  A_T0,   A_P,      A_T0,   1'b0);
      6'd30: u = mk(OP_C32,  A_P,    A_T0,     A_ZERO, 1'b0);
      6'd31: u = mk(OP_MUL,  A_T0,   A_T9,     A_T6,   1'b0);
      6'd32: u = mk(OP_ADD,  A_T0,   A_V,      A_T0,   1'b0);
      6'd33: u = mk(OP_C32,  A_V,    A_T0,     A_ZERO, 1'b0);
      6'd34: u = mk(OP_MUL,  A_T0,   A_T4,     A_T9,   1'b0);
      6'd35: u = mk(OP_SUB,  A_T0,   A_T5,     A_T0,   1'b0);
      6'd36: u = mk(OP_CVAR, A_CVV,  A_T0,     A_ZERO, 1'b0);
      6'd37: u = mk(OP_MUL,  A_T0,   A_T4,     A_T8,   1'b0);
      6'd38: u = mk(OP_SUB,  A_T0,   A_T4,     A_T0,   1'b0);
      6'd39: u = mk(OP_CCOV, A_CPV,  A_T0,     A_ZERO, 1'b0);
      6'd40: u = mk(OP_MUL,  A_T0,   A_T3,     A_T8,   1'b0);
      6'd41: u = mk(OP_SUB,  A_T0,   A_T3,     A_T0,   1'b0);
      6'd42: u = mk(OP_CVAR, A_CPP,  A_T0,     A_ZERO, 1'b0);
      6'd43: u = mk(OP_OUTA, A_ZERO, A_P,      A_V,    1'b0);
      6'd44: u = mk(OP_OUTB, A_ZERO, A_CPP,    A_ZERO, 1'b1);
      6'd45: u = mk(OP_C32,  A_P,    A_MEAS,   A_ZERO, 1'b0);
      6'd46: u = mk(OP_C32,  A_V,    A_SVEL,   A_ZERO, 1'b0);
      6'd47: u = mk(OP_CVAR, A_CPP,  A_INITPP, A_ZERO, 1'b0);
      6'd48: u = mk(OP_C32,  A_CPV,  A_ZERO,   A_ZERO, 1'b0);
      6'd49: u = mk(OP_CVAR, A_CVV,  A_ACC,    A_ZERO, 1'b0);
      6'd50: u = mk(OP_OUTA, A_ZERO, A_P,      A_V,    1'b0);
      default: u = mk(OP_OUTB, A_ZERO, A_CPP,  A_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/kpvf_if.sv =====
// Valid/ready channel interfaces for the Kalman filter: config, request and result.
// Depends on nothing.
interface kpvf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] accel_variance;
  modport source (output valid, output accel_variance, input ready);
  modport sink (input valid, input accel_variance, output ready);
endinterface

interface kpvf_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] measurement;
  logic [31:0]        measurement_variance;
  logic [23:0]        time_step;
  logic signed [31:0] start_velocity;
  modport source (output valid, output command, output measurement,
                  output measurement_variance, output time_step, output start_velocity,
                  input ready);
  modport sink (input valid, input command, input measurement,
                input measurement_variance, input time_step, input start_velocity,
                output ready);
endinterface

interface kpvf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic [46:0]        position_variance;
  logic               rejected;
  modport source (output valid, output position, output velocity,
                  output position_variance, output rejected, input ready);
  modport sink (input valid, input position, input velocity,
                input position_variance, input rejected, output ready);
endinterface

// ===== rtl/kpvf_datapath.sv =====
// Datapath: register file, sequential multiplier, bit-serial divider, saturating ALU, output regs.
// Depends on kpvf_pkg.
module kpvf_datapath #(
  parameter int unsigned FRAC_BITS = kpvf_pkg::FRAC_BITS_DEF,
  parameter int unsigned COV_WIDTH = kpvf_pkg::COV_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] measurement_i,
  input  logic [31:0]        measurement_variance_i,
  input  logic [23:0]        time_step_i,
  input  logic signed [31:0] start_velocity_i,
  input  kpvf_pkg::dp_cmd_t  cmd_i,
  output kpvf_pkg::dp_stat_t stat_o,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic [46:0]        position_variance_o,
  output logic               rejected_o
);
  import kpvf_pkg::*;

  localparam logic [63:0] CovMax     = (64'd1 << (COV_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] PpRaw      = 64'd1000000 << FRAC_BITS;
  localparam logic [63:0] InitPp     = (PpRaw > CovMax) ? CovMax : PpRaw;
  localparam logic [63:0] AccReset   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] S32Max     = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] S32Min     = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] S64Max     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] Mag63Max   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [46:0] PvMax      = 47'h7FFF_FFFF_FFFF;
  localparam logic [127:0] RoundHalf = 128'd1 << (FRAC_BITS - 1);

  logic [63:0] mem_q [16];
  logic [15:0] vld_q;
  logic [31:0] accel_q;
  logic signed [31:0] meas_q, svel_q;
  logic [31:0] varz_q;
  logic [23:0] dt_q;
  logic [63:0] rda_q, rdb_q;
  logic        va_q, vb_q;
  logic [4:0]  sa_q, sb_q;
  logic [63:0] opa, opb;
  logic [7:0]  ecnt_q;
  logic        done;
  uop_t        u;

  // multiplier
  logic [63:0]  ma_q, mb_q, pp_q;
  logic [1:0]   ppk_q, mk;
  logic [31:0]  xs, ys;
  logic [127:0] acc_q, ppw, ppsh, rnd, mshr;
  logic [62:0]  mmag;
  logic [63:0]  mul_res;
  // divider
  logic [63:0]  rem_q;
  logic [127:0] nq_q;
  logic [64:0]  r2, rdiff;
  logic         ge;
  logic [62:0]  dmag;
  logic [63:0]  div_res;
  // alu
  logic [64:0]  add65, sub65;
  logic [63:0]  ccov, res;

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sat64(logic [64:0] s);
    logic [63:0] r;
    if (s[64] != s[63]) begin
      r = s[64] ? ~S64Max : S64Max;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] operand(logic [4:0] s, logic [63:0] rd, logic v,
                                          logic [31:0] meas, logic [31:0] varz,
                                          logic [23:0] dt, logic [31:0] acc,
                                          logic [31:0] svel);
    logic [63:0] r;
    case (s)
      A_MEAS:   r = {{32{meas[31]}}, meas};
      A_VARZ:   r = {32'd0, varz};
      A_DT:     r = {40'd0, dt};
      A_ACC:    r = {32'd0, acc};
      A_SVEL:   r = {{32{svel[31]}}, svel};
      A_INITPP: r = InitPp;
      default: begin
        if (s[4]) begin
          r = 64'd0;
        end else if (v) begin
          r = rd;
        end else if (s == A_CPP) begin
          r = InitPp;
        end else if (s == A_CVV) begin
          r = AccReset;
        end else begin
          r = 64'd0;
        end
      end
    endcase
    return r;
  endfunction

  assign u   = cmd_i.uop;
  assign opa = operand(sa_q, rda_q, va_q, meas_q, varz_q, dt_q, accel_q, svel_q);
  assign opb = operand(sb_q, rdb_q, vb_q, meas_q, varz_q, dt_q, accel_q, svel_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= AccReset[31:0];
    end else if (cfg_valid_i) begin
      accel_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meas_q <= measurement_i;
      varz_q <= measurement_variance_i;
      dt_q   <= time_step_i;
      svel_q <= start_velocity_i;
    end
  end

  // register file read, data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rda_q <= mem_q[u.src_a[3:0]];
      rdb_q <= mem_q[u.src_b[3:0]];
      va_q  <= vld_q[u.src_a[3:0]];
      vb_q  <= vld_q[u.src_b[3:0]];
      sa_q  <= u.src_a;
      sb_q  <= u.src_b;
    end
  end

  always_comb begin
    case (u.op)
      OP_MUL:  done = cmd_i.exec && (ecnt_q == MUL_LAST);
      OP_DIV:  done = cmd_i.exec && (ecnt_q == DIV_LAST);
      default: done = cmd_i.exec && (ecnt_q == 8'd0);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_q <= 8'd0;
    end else if (!cmd_i.exec || done) begin
      ecnt_q <= 8'd0;
    end else begin
      ecnt_q <= ecnt_q + 8'd1;
    end
  end

  // multiplier: magnitudes, four 32x32 partial products, accumulate, round and saturate
  always_comb begin
    mk = ecnt_q[1:0] - 2'd1;
    xs = mk[1] ? ma_q[63:32] : ma_q[31:0];
    ys = mk[0] ? mb_q[63:32] : mb_q[31:0];
    ppw = {64'd0, pp_q};
    case (ppk_q)
      2'd0:    ppsh = ppw;
      2'd3:    ppsh = ppw << 64;
      default: ppsh = ppw << 32;
    endcase
    rnd  = acc_q + RoundHalf;
    mshr = rnd >> FRAC_BITS;
    mmag = (|mshr[127:63]) ? Mag63Max : mshr[62:0];
    mul_res = (opa[63] ^ opb[63]) ? (64'd0 - {1'b0, mmag}) : {1'b0, mmag};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && u.op == OP_MUL) begin
      if (ecnt_q == 8'd0) begin
        ma_q  <= mag(opa);
        mb_q  <= mag(opb);
        acc_q <= 128'd0;
      end
      if (ecnt_q >= 8'd1 && ecnt_q <= 8'd4) begin
        pp_q  <= {32'd0, xs} * {32'd0, ys};
        ppk_q <= mk;
      end
      if (ecnt_q >= 8'd2 && ecnt_q <= 8'd5) begin
        acc_q <= acc_q + ppsh;
      end
    end
  end

  // restoring divider, one quotient bit per cycle, quotient shifts into the dividend reg
  always_comb begin
    r2    = {rem_q, nq_q[127]};
    ge    = r2 >= {1'b0, opb};
    rdiff = r2 - {1'b0, opb};
    dmag  = (|nq_q[127:63]) ? Mag63Max : nq_q[62:0];
    if (opb == 64'd0) begin
      div_res = 64'd0;
    end else begin
      div_res = opa[63] ? (64'd0 - {1'b0, dmag}) : {1'b0, dmag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && u.op == OP_DIV) begin
      if (ecnt_q == 8'd0) begin
        nq_q  <= ({64'd0, mag(opa)} << FRAC_BITS) + {65'd0, opb[63:1]};
        rem_q <= 64'd0;
      end else if (ecnt_q != DIV_LAST) begin
        rem_q <= ge ? rdiff[63:0] : r2[63:0];
        nq_q  <= {nq_q[126:0], ge};
      end
    end
  end

  // add, subtract, shifts, clamps and result select
  always_comb begin
    add65 = {opa[63], opa} + {opb[63], opb};
    sub65 = {opa[63], opa} - {opb[63], opb};
    if ($signed(opa) > $signed(CovMax)) begin
      ccov = CovMax;
    end else if ($signed(opa) < $signed(~CovMax)) begin
      ccov = ~CovMax;
    end else begin
      ccov = opa;
    end
    case (u.op)
      OP_MUL:  res = mul_res;
      OP_DIV:  res = div_res;
      OP_ADD:  res = sat64(add65);
      OP_SUB:  res = sat64(sub65);
      OP_SHR1: res = {opa[63], opa[63:1]} + {63'd0, opa[0]};
      OP_SHR2: res = {{2{opa[63]}}, opa[63:2]} + {63'd0, opa[1]};
      OP_C32: begin
        if ($signed(opa) > $signed(S32Max)) begin
          res = S32Max;
        end else if ($signed(opa) < $signed(S32Min)) begin
          res = S32Min;
        end else begin
          res = opa;
        end
      end
      OP_CCOV: res = ccov;
      OP_CVAR: res = opa[63] ? 64'd0 : ccov;
      default: res = opa;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (done && u.op != OP_OUTA && u.op != OP_OUTB) begin
      mem_q[u.dst[3:0]] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (done && u.op != OP_OUTA && u.op != OP_OUTB) begin
      vld_q[u.dst[3:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && u.op == OP_OUTA) begin
      position_o <= opa[31:0];
      velocity_o <= opb[31:0];
      rejected_o <= cmd_i.rej;
    end
    if (done && u.op == OP_OUTB) begin
      position_variance_o <= (opa > {17'd0, PvMax}) ? PvMax : opa[46:0];
    end
  end

  assign stat_o.done    = done;
  assign stat_o.dt_zero = (time_step_i == 24'd0);

endmodule

// ===== rtl/kpvf_ctrl.sv =====
// Controller: accepts requests, walks the micro-op program, owns the result valid flag.
// Depends on kpvf_pkg.
module kpvf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_command_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kpvf_pkg::dp_cmd_t  cmd_o,
  input  kpvf_pkg::dp_stat_t stat_i
);
  import kpvf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic [5:0] pc_q, pc_d;
  logic       rej_q, rej_d;
  logic       out_valid_q, out_valid_d;
  logic       stall;
  uop_t       uop;

  assign uop   = uop_rom(pc_q);
  // results wait for the previous one to leave before the output regs are loaded
  assign stall = (uop.op == OP_OUTA) && out_valid_q;

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    rej_d       = rej_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
          rej_d   = !in_command_i && stat_i.dt_zero;
          if (in_command_i) begin
            pc_d = PC_RST;
          end else if (stat_i.dt_zero) begin
            pc_d = PC_REJ;
          end else begin
            pc_d = PC_UPD;
          end
        end
      end
      S_READ: begin
        if (!stall) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.done) begin
          if (uop.is_last) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
          end else begin
            state_d = S_READ;
            pc_d    = pc_q + 6'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= PC_UPD;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.rd      = (state_q == S_READ) && !stall;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.rej     = rej_q;
  assign cmd_o.uop     = uop;

endmodule

// ===== rtl/kalman_position_velocity_filter.sv =====
// Top level of the two-state (position, velocity) constant-velocity Kalman filter.
// Depends on kpvf_pkg, kpvf_if, kpvf_ctrl and kpvf_datapath.
//
//   channel  dir  payload                                          request taken when
//   cfg_i    in   accel_variance (Q16.16 unsigned)                  valid && ready (always ready)
//   in_i     in   command, measurement, measurement_variance,       valid && ready
//                 time_step, start_velocity
//   out_o    out  position, velocity, position_variance, rejected   valid && ready
//
// An update request's run time is dominated by the bit-serial divider (two gains); the 15
// products share the 32x32 multiplier and every other micro-op runs on the ALU. A reset
// request and a rejected (zero time step) request run short programs. One request is in
// work at a time.
// Reset clears control state and register valid bits; no clearing pass. A stalled result holds
// in the output registers while the next request is accepted and worked up to its result load.
module kalman_position_velocity_filter #(
  parameter int unsigned FRAC_BITS = kpvf_pkg::FRAC_BITS_DEF,
  parameter int unsigned COV_WIDTH = kpvf_pkg::COV_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kpvf_cfg_if.sink  cfg_i,
  kpvf_in_if.sink   in_i,
  kpvf_out_if.source out_o
);
  import kpvf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  // the user must issue config writes only while idle; the block itself does not enforce this
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  kpvf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  kpvf_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .COV_WIDTH (COV_WIDTH)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_i.valid),
    .cfg_data_i             (cfg_i.accel_variance),
    .measurement_i          (in_i.measurement),
    .measurement_variance_i (in_i.measurement_variance),
    .time_step_i            (in_i.time_step),
    .start_velocity_i       (in_i.start_velocity),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .position_o             (out_o.position),
    .velocity_o             (out_o.velocity),
    .position_variance_o    (out_o.position_variance),
    .rejected_o             (out_o.rejected)
  );

  // a request keeps the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again right after a request");

  // a result only appears at the end of a program, never while the block sits idle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result raised without work in progress");

  // the micro-op unit only reports completion while executing
  a_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> cmd.exec)
    else $error("completion outside execute");

endmodule
